// File: design/sbb_pkg.sv
// ============================================================================
// sbb_pkg
// Shared widths, codes and controller/datapath types for the box blur block.
// ============================================================================
package sbb_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_RADIUS = 8;
  localparam int PIX_W      = 16;
  localparam int NUM_CH     = 3;
  localparam int PIX3_W     = NUM_CH * PIX_W;

  localparam int LINE_ROWS  = 2 * MAX_RADIUS;
  localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
  localparam int LROW_W     = $clog2(LINE_ROWS);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ADDR_W     = LROW_W + COL_W;
  localparam int LINE_DEPTH = LINE_ROWS * MAX_WIDTH;

  localparam int RAD_W      = 4;
  localparam int WID_W      = 12;
  localparam int HGT_W      = 13;
  localparam int POS_W      = 24;
  localparam int SUM_W      = $clog2(WIN_DEPTH * (2 ** PIX_W - 1) + 1);
  localparam int CNT_W      = $clog2(WIN_DEPTH + 1);
  localparam int IDX_W      = $clog2(WIN_DEPTH);
  localparam int STEP_W     = $clog2(SUM_W);

  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [RAD_W-1:0] RADIUS_RST = 4'd2;
  localparam logic [WID_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [HGT_W-1:0] HEIGHT_RST = 13'd480;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_COL_ADDR,
    S_COL_ACC,
    S_COL_DIV,
    S_COL_WR,
    S_STORE,
    S_CHECK,
    S_ROW_ACC,
    S_ROW_DIV,
    S_LOAD
  } sbb_state_t;

  typedef struct packed {
    logic take;
    logic col_start;
    logic col_read;
    logic col_acc;
    logic div_step;
    logic col_write;
    logic store;
    logic row_start;
    logic row_acc;
    logic out_load;
  } sbb_cmd_t;

  typedef struct packed {
    logic cfg_busy;
    logic pix_path;
    logic do_col;
    logic col_last;
    logic row_last;
    logic div_last;
    logic emit;
  } sbb_stat_t;

endpackage

// File: design/sbb_if.sv
// ============================================================================
// sbb_pix_if / sbb_res_if
// Valid/ready channels carrying input pixels and blurred result pixels.
// ============================================================================
interface sbb_pix_if;
  import sbb_pkg::*;
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [PIX_W-1:0] in_red;
  logic [PIX_W-1:0] in_green;
  logic [PIX_W-1:0] in_blue;
  modport source (output valid, opcode, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, opcode, in_red, in_green, in_blue, output ready);
endinterface

interface sbb_res_if;
  import sbb_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  logic             end_of_frame;
  modport source (output valid, out_red, out_green, out_blue, end_of_frame, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, end_of_frame, output ready);
endinterface

// File: design/separable_box_blur_rgb.sv
// ============================================================================
// separable_box_blur_rgb
// Separable RGB box blur on a raster pixel stream, 8.8 fixed point.
// ============================================================================
// One word is handled at a time. A pixel word that only moves position passes
// through decide, store and check, and a drain word that does nothing through
// decide and check; a word that produces a column mean adds an address and an
// accumulate step per row read from the single-port line store (up to 2R+1
// rows), the serial divide and a write of the mean; a word that releases an
// output adds an accumulate step per column in the clipped row window (up to
// 2R+1), another serial divide and a load of the output register. A loaded
// result is held until taken while the next word goes on; that word waits at
// its own load until the register is free. The serial divide, one quotient
// bit per cycle for all three channels, and the line store port set the pace.
// Results lag input by R rows plus R pixels; drain words (opcode 1) flush the
// rest of a frame. A register write restarts the frame, and the block takes
// no word in the cycle after a write or after reset.
module separable_box_blur_rgb (
  input  logic                          clk,
  input  logic                          rst,
  sbb_pix_if.sink                       pix_in,
  sbb_res_if.source                     pix_out,
  input  logic                          cfg_write,
  input  logic [sbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbb_pkg::CFG_W-1:0]     cfg_data
);
  import sbb_pkg::*;

  sbb_cmd_t  cmd;
  sbb_stat_t stat;

  // sequencer
  sbb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  sbb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_opcode (pix_in.opcode),
    .in_red    (pix_in.in_red),
    .in_green  (pix_in.in_green),
    .in_blue   (pix_in.in_blue),
    .out_red   (pix_out.out_red),
    .out_green (pix_out.out_green),
    .out_blue  (pix_out.out_blue),
    .out_eof   (pix_out.end_of_frame)
  );

endmodule

// File: design/sbb_ctrl.sv
// ============================================================================
// sbb_ctrl
// Sequencer for one word: column pass, line store write, row pass, output.
// ============================================================================
module sbb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sbb_pkg::sbb_stat_t stat,
  output sbb_pkg::sbb_cmd_t  cmd
);
  import sbb_pkg::*;

  sbb_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold the result word valid until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid && !stat.cfg_busy) state_next = S_DECIDE;
      S_DECIDE: begin
        if (stat.do_col) state_next = S_COL_ADDR;
        else if (stat.pix_path) state_next = S_STORE;
        else state_next = S_CHECK;
      end
      S_COL_ADDR: state_next = S_COL_ACC;
      S_COL_ACC:  state_next = stat.col_last ? S_COL_DIV : S_COL_ADDR;
      S_COL_DIV:  if (stat.div_last) state_next = S_COL_WR;
      S_COL_WR:   state_next = stat.pix_path ? S_STORE : S_CHECK;
      S_STORE:    state_next = S_CHECK;
      S_CHECK:    state_next = stat.emit ? S_ROW_ACC : S_IDLE;
      S_ROW_ACC:  if (stat.row_last) state_next = S_ROW_DIV;
      S_ROW_DIV:  if (stat.div_last) state_next = S_LOAD;
      S_LOAD:     if (!out_valid || out_ready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !stat.cfg_busy;
        cmd.take = in_valid && !stat.cfg_busy;
      end
      S_DECIDE:   cmd.col_start = stat.do_col;
      S_COL_ADDR: cmd.col_read  = 1'b1;
      S_COL_ACC:  cmd.col_acc   = 1'b1;
      S_COL_DIV:  cmd.div_step  = 1'b1;
      S_COL_WR:   cmd.col_write = 1'b1;
      S_STORE:    cmd.store     = 1'b1;
      S_CHECK:    cmd.row_start = stat.emit;
      S_ROW_ACC:  cmd.row_acc   = 1'b1;
      S_ROW_DIV:  cmd.div_step  = 1'b1;
      S_LOAD:     cmd.out_load  = !out_valid || out_ready;
      default:    cmd = '0;
    endcase
  end

endmodule

// File: design/sbb_dp.sv
// ============================================================================
// sbb_dp
// Datapath: configuration, positions, line store, column mean window,
// channel accumulators with serial dividers shared by both passes, and the output register.
// ============================================================================
module sbb_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  sbb_pkg::sbb_cmd_t              cmd,
  output sbb_pkg::sbb_stat_t             stat,
  input  logic                           cfg_write,
  input  logic [sbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbb_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_opcode,
  input  logic [sbb_pkg::PIX_W-1:0]      in_red,
  input  logic [sbb_pkg::PIX_W-1:0]      in_green,
  input  logic [sbb_pkg::PIX_W-1:0]      in_blue,
  output logic [sbb_pkg::PIX_W-1:0]      out_red,
  output logic [sbb_pkg::PIX_W-1:0]      out_green,
  output logic [sbb_pkg::PIX_W-1:0]      out_blue,
  output logic                           out_eof
);
  import sbb_pkg::*;

  // configuration
  logic [RAD_W-1:0] cfg_radius;
  logic [WID_W-1:0] cfg_width;
  logic [HGT_W-1:0] cfg_height;
  logic             cfg_busy;
  logic             cfg_hit;
  logic [POS_W-1:0] total;
  logic [RAD_W-1:0] eff_r;
  logic [WID_W-1:0] eff_w;
  logic [HGT_W-1:0] eff_h;

  // positions
  logic [POS_W-1:0] in_pos;
  logic [COL_W-1:0] in_col;
  logic [HGT_W-1:0] in_row;
  logic [COL_W-1:0] cm_col;
  logic [HGT_W-1:0] cm_row;
  logic [IDX_W-1:0] cm_idx;
  logic [POS_W-1:0] out_pos;
  logic [COL_W-1:0] out_col;
  logic [IDX_W-1:0] out_idx;
  logic [CNT_W-1:0] hcount;

  // current word
  logic [PIX3_W-1:0] item_pix;
  logic              item_drain;

  // stores
  logic [PIX3_W-1:0] line_mem [LINE_DEPTH];
  logic [PIX3_W-1:0] rd_data;
  logic [PIX3_W-1:0] win [WIN_DEPTH];

  // loop counters and accumulators
  logic [HGT_W-1:0]  rr;
  logic [COL_W-1:0]  cc;
  logic [IDX_W-1:0]  hidx;
  logic [CNT_W-1:0]  n_cnt;
  logic [STEP_W-1:0] div_cnt;
  logic [SUM_W-1:0]  sum [NUM_CH];
  logic [CNT_W-1:0]  rem [NUM_CH];

  // derived values
  logic [HGT_W-1:0]  h_max;
  logic [COL_W-1:0]  w_max;
  logic [HGT_W-1:0]  col_lo;
  logic [HGT_W:0]    col_hi_full;
  logic [HGT_W-1:0]  col_hi;
  logic [COL_W-1:0]  row_dl;
  logic [COL_W:0]    row_hi_full;
  logic [COL_W-1:0]  row_hi;
  logic [IDX_W:0]    hidx_wrap;
  logic [IDX_W-1:0]  hidx_start;
  logic [POS_W:0]    done_cnt;
  logic [POS_W-1:0]  remain;
  logic [CNT_W-1:0]  r_plus1;
  logic [CNT_W-1:0]  need_cnt;
  logic              use_cur;
  logic [PIX3_W-1:0] addend;
  logic              frame_end;
  logic              restart;

  // clamp configuration to usable values
  always_comb begin
    eff_r = (cfg_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : cfg_radius;
    if (cfg_width == '0) eff_w = WID_W'(1);
    else if (cfg_width > WID_W'(MAX_WIDTH)) eff_w = WID_W'(MAX_WIDTH);
    else eff_w = cfg_width;
    eff_h = (cfg_height == '0) ? HGT_W'(1) : cfg_height;
    h_max = eff_h - HGT_W'(1);
    w_max = COL_W'(eff_w - WID_W'(1));
  end

  assign cfg_hit = cfg_write &&
                   (cfg_index == REG_RADIUS || cfg_index == REG_WIDTH ||
                    cfg_index == REG_HEIGHT);

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_radius <= RADIUS_RST;
      cfg_width  <= WIDTH_RST;
      cfg_height <= HEIGHT_RST;
      cfg_busy   <= 1'b1;
    end else begin
      cfg_busy <= cfg_write;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_RADIUS: cfg_radius <= cfg_data[RAD_W-1:0];
          REG_WIDTH:  cfg_width  <= cfg_data[WID_W-1:0];
          REG_HEIGHT: cfg_height <= cfg_data[HGT_W-1:0];
          default:    cfg_radius <= cfg_radius;
        endcase
      end
    end
  end

  // frame size, registered from the clamped width and height
  always_ff @(posedge clk) begin
    total <= POS_W'(eff_w * eff_h);
  end

  // column pass bounds
  always_comb begin
    col_lo      = (cm_row >= HGT_W'(eff_r)) ? cm_row - HGT_W'(eff_r) : '0;
    col_hi_full = {1'b0, cm_row} + (HGT_W+1)'(eff_r);
    col_hi      = (col_hi_full > {1'b0, h_max}) ? h_max : col_hi_full[HGT_W-1:0];
  end

  // row pass bounds and starting window slot
  always_comb begin
    row_dl      = (out_col >= COL_W'(eff_r)) ? COL_W'(eff_r) : out_col;
    row_hi_full = {1'b0, out_col} + (COL_W+1)'(eff_r);
    row_hi      = (row_hi_full > {1'b0, w_max}) ? w_max : row_hi_full[COL_W-1:0];
    hidx_wrap   = {1'b0, out_idx} + (IDX_W+1)'(WIN_DEPTH) - (IDX_W+1)'(row_dl);
    hidx_start  = (hidx_wrap >= (IDX_W+1)'(WIN_DEPTH)) ?
                  IDX_W'(hidx_wrap - (IDX_W+1)'(WIN_DEPTH)) : hidx_wrap[IDX_W-1:0];
  end

  // output readiness
  always_comb begin
    done_cnt = {1'b0, out_pos} + (POS_W+1)'(hcount);
    remain   = total - out_pos;
    r_plus1  = CNT_W'(eff_r) + CNT_W'(1);
    need_cnt = (remain < POS_W'(r_plus1)) ? remain[CNT_W-1:0] : r_plus1;
  end

  assign stat.cfg_busy = cfg_busy;
  assign stat.pix_path = !item_drain && (in_pos < total);
  assign stat.do_col   = stat.pix_path ? (in_row >= HGT_W'(eff_r)) :
                         ((in_pos >= total) && (done_cnt < (POS_W+1)'(total)));
  assign stat.col_last = (rr == col_hi);
  assign stat.row_last = (cc == row_hi);
  assign stat.div_last = (div_cnt == STEP_W'(SUM_W - 1));
  assign stat.emit     = (hcount != '0) && (hcount >= need_cnt) && (out_pos < total);

  assign use_cur   = stat.pix_path && (rr == col_hi);
  assign addend    = cmd.row_acc ? win[hidx] : (use_cur ? item_pix : rd_data);
  assign frame_end = (out_pos + POS_W'(1)) >= total;
  assign restart   = cfg_hit || (cmd.out_load && frame_end);

  // latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_pix   <= {in_red, in_green, in_blue};
      item_drain <= in_opcode;
    end
  end

  // line store: one read or one write per cycle
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      line_mem[{in_row[LROW_W-1:0], in_col}] <= item_pix;
    end
    if (cmd.col_read) begin
      rd_data <= line_mem[{rr[LROW_W-1:0], cm_col}];
    end
  end

  // column mean window
  always_ff @(posedge clk) begin
    if (cmd.col_write) begin
      win[cm_idx] <= {sum[0][PIX_W-1:0], sum[1][PIX_W-1:0], sum[2][PIX_W-1:0]};
    end
  end

  // positions and pending column means
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_pos  <= '0;
      in_col  <= '0;
      in_row  <= '0;
      cm_col  <= '0;
      cm_row  <= '0;
      cm_idx  <= '0;
      out_pos <= '0;
      out_col <= '0;
      out_idx <= '0;
      hcount  <= '0;
    end else begin
      // advance input position
      if (cmd.store) begin
        in_pos <= in_pos + POS_W'(1);
        if (in_col == w_max) begin
          in_col <= '0;
          in_row <= in_row + HGT_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end
      // advance column mean position
      if (cmd.col_write) begin
        cm_idx <= (cm_idx == IDX_W'(WIN_DEPTH - 1)) ? '0 : cm_idx + IDX_W'(1);
        if (cm_col == w_max) begin
          cm_col <= '0;
          cm_row <= cm_row + HGT_W'(1);
        end else begin
          cm_col <= cm_col + COL_W'(1);
        end
      end
      // count pending means, output position
      if (cmd.col_write) begin
        hcount <= hcount + CNT_W'(1);
      end else if (cmd.out_load) begin
        hcount <= hcount - CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_pos <= out_pos + POS_W'(1);
        out_idx <= (out_idx == IDX_W'(WIN_DEPTH - 1)) ? '0 : out_idx + IDX_W'(1);
        out_col <= (out_col == w_max) ? '0 : out_col + COL_W'(1);
      end
    end
  end

  // loop counters
  always_ff @(posedge clk) begin
    if (cmd.col_start) begin
      rr <= col_lo;
    end else if (cmd.col_acc) begin
      rr <= rr + HGT_W'(1);
    end
    if (cmd.row_start) begin
      cc   <= out_col - row_dl;
      hidx <= hidx_start;
    end else if (cmd.row_acc) begin
      cc   <= cc + COL_W'(1);
      hidx <= (hidx == IDX_W'(WIN_DEPTH - 1)) ? '0 : hidx + IDX_W'(1);
    end
    if (cmd.col_start || cmd.row_start) begin
      n_cnt   <= '0;
      div_cnt <= '0;
    end else begin
      if (cmd.col_acc || cmd.row_acc) n_cnt <= n_cnt + CNT_W'(1);
      if (cmd.div_step) div_cnt <= div_cnt + STEP_W'(1);
    end
  end

  // accumulate, then divide in place: one quotient bit per cycle
  always_ff @(posedge clk) begin
    logic [CNT_W:0] trial;
    for (int k = 0; k < NUM_CH; k++) begin
      trial = {rem[k], sum[k][SUM_W-1]};
      if (cmd.col_start || cmd.row_start) begin
        sum[k] <= '0;
        rem[k] <= '0;
      end else if (cmd.col_acc || cmd.row_acc) begin
        sum[k] <= sum[k] + SUM_W'(addend[PIX3_W-1-k*PIX_W -: PIX_W]);
      end else if (cmd.div_step) begin
        if (trial >= {1'b0, n_cnt}) begin
          rem[k] <= CNT_W'(trial - {1'b0, n_cnt});
          sum[k] <= {sum[k][SUM_W-2:0], 1'b1};
        end else begin
          rem[k] <= trial[CNT_W-1:0];
          sum[k] <= {sum[k][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_red   <= sum[0][PIX_W-1:0];
      out_green <= sum[1][PIX_W-1:0];
      out_blue  <= sum[2][PIX_W-1:0];
      out_eof   <= frame_end;
    end
  end

endmodule

// File: design/sbb_checker.sv
// ============================================================================
// sbb_checker
// Port-level checks on the word handshakes of the box blur block.
// ============================================================================
module sbb_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before taken");

  // drop ready after a word is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after accept");

  // no result right after reset
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown after reset");

endmodule

bind separable_box_blur_rgb sbb_checker u_sbb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready)
);
